[src/assert_macros.svh]
// Assertion macros shared by the RTL. Synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/bkmh_pkg.sv]
package bkmh_pkg;

    localparam logic [31:0] LaneInit   = 32'hf721b64d;
    localparam int          BlockBytes = 12;
    localparam int          PosW       = $clog2(BlockBytes + 1);
    localparam int          MixSteps   = 9;
    localparam int          MixStepW   = $clog2(MixSteps);
    localparam int          QueueDepth = 4;
    localparam int          QueuePtrW  = $clog2(QueueDepth);
    localparam int          QueueCntW  = $clog2(QueueDepth + 1);

    // One unit of work for the mixing engine.
    typedef struct packed {
        logic        first;  // first entry of a key: start lanes from init and seed
        logic        blk;    // words form a full 12-byte block
        logic        fin;    // key ends with this entry
        logic [31:0] seed;
        logic [31:0] wa;
        logic [31:0] wb;
        logic [31:0] wc;     // block c word, or shifted tail plus length
        logic [31:0] fc;     // length, added before the closing mix after a full block
    } q_entry_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } lanes_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIX,
        BK_LEN
    } back_state_t;

    // One of the nine steps of the mix; each step rewrites a single lane.
    function automatic lanes_t mix_step(lanes_t l, logic [MixStepW-1:0] k);
        lanes_t r;
        r = l;
        case (k)
            MixStepW'(0): r.a = (l.a - l.b - l.c) ^ (l.c >> 13);
            MixStepW'(1): r.b = (l.b - l.c - l.a) ^ (l.a << 8);
            MixStepW'(2): r.c = (l.c - l.a - l.b) ^ (l.b >> 13);
            MixStepW'(3): r.a = (l.a - l.b - l.c) ^ (l.c >> 12);
            MixStepW'(4): r.b = (l.b - l.c - l.a) ^ (l.a << 16);
            MixStepW'(5): r.c = (l.c - l.a - l.b) ^ (l.b >> 5);
            MixStepW'(6): r.a = (l.a - l.b - l.c) ^ (l.c >> 3);
            MixStepW'(7): r.b = (l.b - l.c - l.a) ^ (l.a << 10);
            MixStepW'(8): r.c = (l.c - l.a - l.b) ^ (l.b >> 15);
            default:      r = l;
        endcase
        return r;
    endfunction

endpackage

[src/bkmh_front.sv]
module bkmh_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                q_push,
    output bkmh_pkg::q_entry_t  q_entry,
    input  logic                q_full
);
    import bkmh_pkg::*;

    localparam logic [PosW-1:0] BlockEnd = PosW'(BlockBytes);

    logic              in_key_reg, in_key_next;
    logic              first_reg, first_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [31:0]       wa_reg, wa_next;
    logic [31:0]       wb_reg, wb_next;
    logic [31:0]       wc_reg, wc_next;
    logic [31:0]       len_reg, len_next;
    logic [31:0]       seed_reg, seed_next;

    logic              accept;
    logic              first_item;
    logic              first0;
    logic [PosW-1:0]   pos0, pos1;
    logic [31:0]       wa0, wb0, wc0, wa1, wb1, wc1;
    logic [31:0]       len0, len1;
    logic [31:0]       seed_cur;
    logic [31:0]       byte_word;
    logic              blk;
    logic [7:0]        data_byte;
    logic              has_byte;
    logic              is_last;

    assign data_byte = s_tdata[7:0];
    assign has_byte  = s_tuser;
    assign is_last   = s_tlast;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        first_item = !in_key_reg;
        first0     = first_item ? 1'b1 : first_reg;
        pos0       = first_item ? '0 : pos_reg;
        wa0        = first_item ? '0 : wa_reg;
        wb0        = first_item ? '0 : wb_reg;
        wc0        = first_item ? '0 : wc_reg;
        len0       = first_item ? '0 : len_reg;
        seed_cur   = first_item ? s_tdata[39:8] : seed_reg;

        byte_word = {24'd0, data_byte} << {pos0[1:0], 3'b000};
        wa1  = wa0;
        wb1  = wb0;
        wc1  = wc0;
        len1 = len0;
        pos1 = pos0;
        if (has_byte)
        begin
            case (pos0[3:2])
                2'd0:    wa1 = wa0 | byte_word;
                2'd1:    wb1 = wb0 | byte_word;
                default: wc1 = wc0 | byte_word;
            endcase
            len1 = len0 + 32'd1;
            pos1 = pos0 + PosW'(1);
        end
        blk = has_byte && (pos1 == BlockEnd);

        q_entry.first = first0;
        q_entry.blk   = blk;
        q_entry.fin   = is_last;
        q_entry.seed  = seed_cur;
        q_entry.wa    = wa1;
        q_entry.wb    = wb1;
        q_entry.fc    = len1;
        // tail c bytes go in one byte higher, together with the length
        q_entry.wc    = blk ? wc1 : ({wc1[23:0], 8'd0} + len1);
        q_push        = accept && (blk || is_last);

        in_key_next = in_key_reg;
        first_next  = first_reg;
        pos_next    = pos_reg;
        wa_next     = wa_reg;
        wb_next     = wb_reg;
        wc_next     = wc_reg;
        len_next    = len_reg;
        seed_next   = seed_reg;
        if (accept)
        begin
            in_key_next = !is_last;
            first_next  = q_push ? 1'b0 : first0;
            pos_next    = blk ? '0 : pos1;
            wa_next     = blk ? '0 : wa1;
            wb_next     = blk ? '0 : wb1;
            wc_next     = blk ? '0 : wc1;
            len_next    = len1;
            seed_next   = seed_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_key_reg <= 1'b0;
        end
        else
        begin
            in_key_reg <= in_key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        pos_reg   <= pos_next;
        wa_reg    <= wa_next;
        wb_reg    <= wb_next;
        wc_reg    <= wc_next;
        len_reg   <= len_next;
        seed_reg  <= seed_next;
    end

endmodule

[src/bkmh_queue.sv]
`include "assert_macros.svh"

module bkmh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bkmh_pkg::q_entry_t  push_entry,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output bkmh_pkg::q_entry_t  head
);
    import bkmh_pkg::*;

    localparam logic [QueuePtrW-1:0] PtrLast = QueuePtrW'(QueueDepth - 1);
    localparam logic [QueueCntW-1:0] CntFull = QueueCntW'(QueueDepth);

    q_entry_t               slot_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QueueCntW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CntFull);
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + QueuePtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + QueuePtrW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + QueueCntW'(1);
            2'b01:   count_next = count_reg - QueueCntW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full))
    `ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && !valid))

endmodule

[src/bkmh_back.sv]
`include "assert_macros.svh"

module bkmh_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  bkmh_pkg::q_entry_t  q_head,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata
);
    import bkmh_pkg::*;

    localparam logic [MixStepW-1:0] MixLast = MixStepW'(MixSteps - 1);

    back_state_t            state_reg, state_next;
    logic [MixStepW-1:0]    step_reg, step_next;
    logic                   fin_reg, fin_next;
    logic                   two_reg, two_next;
    logic                   out_valid_reg, out_valid_next;
    lanes_t                 lanes_reg, lanes_next;
    logic [31:0]            fc_reg, fc_next;
    logic [31:0]            out_data_reg, out_data_next;

    lanes_t                 base;
    lanes_t                 mixed;
    logic                   out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        base.a   = q_head.first ? LaneInit : lanes_reg.a;
        base.b   = q_head.first ? LaneInit : lanes_reg.b;
        base.c   = q_head.first ? q_head.seed : lanes_reg.c;
        mixed    = mix_step(lanes_reg, step_reg);
        out_free = !out_valid_reg || m_tready;

        state_next     = state_reg;
        step_next      = step_reg;
        fin_next       = fin_reg;
        two_next       = two_reg;
        lanes_next     = lanes_reg;
        fc_next        = fc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    lanes_next.a = base.a + q_head.wa;
                    lanes_next.b = base.b + q_head.wb;
                    lanes_next.c = base.c + q_head.wc;
                    fin_next     = q_head.fin;
                    two_next     = q_head.blk && q_head.fin;
                    fc_next      = q_head.fc;
                    step_next    = '0;
                    state_next   = BK_MIX;
                end
            end
            BK_MIX:
            begin
                if (step_reg != MixLast)
                begin
                    lanes_next = mixed;
                    step_next  = step_reg + MixStepW'(1);
                end
                else if (two_reg)
                begin
                    lanes_next = mixed;
                    two_next   = 1'b0;
                    state_next = BK_LEN;
                end
                else if (fin_reg)
                begin
                    // hold the last step until the output register frees up
                    if (out_free)
                    begin
                        lanes_next     = mixed;
                        out_data_next  = mixed.c;
                        out_valid_next = 1'b1;
                        state_next     = BK_IDLE;
                    end
                end
                else
                begin
                    lanes_next = mixed;
                    state_next = BK_IDLE;
                end
            end
            BK_LEN:
            begin
                lanes_next.c = lanes_reg.c + fc_reg;
                step_next    = '0;
                state_next   = BK_MIX;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            fin_reg       <= 1'b0;
            two_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            fin_reg       <= fin_next;
            two_reg       <= two_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lanes_reg    <= lanes_next;
        fc_reg       <= fc_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_IMPLY(a_step_range, clk, rst_n, state_reg == BK_MIX, step_reg <= MixLast)
    `ASSERT_NEXT(a_len_then_mix, clk, rst_n, state_reg == BK_LEN, state_reg == BK_MIX && step_reg == '0)
    `ASSERT_IMPLY(a_pop_when_idle, clk, rst_n, q_pop, state_reg == BK_IDLE)

endmodule

[src/byte_key_mixing_hash_top.sv]
// Channel   Direction  Signals                                  Item
// s_*       in         s_tvalid s_tready s_tdata s_tuser s_tlast one key byte (or empty-key end)
// m_*       out        m_tvalid m_tready m_tdata                 one 32-bit hash per key
//
// Cycles: one input item per cycle while the queue has room. Each 12-byte block
// costs the mixing engine one lane add and nine mix steps, so long keys can stream
// at one byte a cycle while the queue has room. When a key's last byte completes a
// block, that entry gets a second pass (length added into lane c, nine mix steps).
// Short keys are bound by the single shared mix step unit, one entry at a time.
// Reset: rst_n clears the control state at once; no clearing pass is needed.
// Stalls: a four-entry queue parts the byte front end from the mixing engine, and
// the result register lets the next key be worked on while a hash waits on m_tready.
module byte_key_mixing_hash_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] seed
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash_value
);
    import bkmh_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_in;
    q_entry_t q_head;

    // Assemble bytes into blocks, track length and seed, hand work to the queue.
    bkmh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_entry  (q_in),
        .q_full   (q_full)
    );

    // Hold pending block and key-end entries so either side can stall on its own.
    bkmh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    // Add words into lanes, mix one step a cycle, drive the result register (last step waits).
    bkmh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
